### hw/rtl/s2d_pkg.sv
// Shared constants and types for the signed binary to decimal ASCII converter.
package s2d_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int DIGIT_SLOTS = 20;
  localparam int CNT_W       = $clog2(VALUE_BITS);
  localparam int REM_W       = $clog2(DIGIT_SLOTS + 1);

  localparam logic [5:0] ASCII_ZERO  = 6'd48;
  localparam logic [5:0] ASCII_MINUS = 6'd45;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef logic [3:0] digit_t;

  // Operation applied to every digit cell in a cycle.
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_CLEAR,
    MODE_DABBLE,
    MODE_SHIFT
  } s2d_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } s2d_state_e;

endpackage

### hw/rtl/s2d_cell.sv
// One BCD digit cell: add-3 adjust and shift during conversion, digit shift during output.
module s2d_cell
  import s2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  s2d_mode_e mode_i,
  input  digit_t    digit_i,
  input  logic      carry_i,
  output digit_t    digit_o,
  output logic      carry_o
);

  digit_t digit_q, digit_d, adj;

  assign adj     = (digit_q >= BCD_ADJ_MIN) ? digit_q + BCD_ADJ : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    case (mode_i)
      MODE_CLEAR:  digit_d = '0;
      MODE_DABBLE: digit_d = {adj[2:0], carry_i};
      MODE_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

### hw/rtl/s2d_chain.sv
// Row of BCD digit cells, least significant digit at cell 0.
module s2d_chain
  import s2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  s2d_mode_e mode_i,
  input  logic      bit_i,
  output digit_t    top_digit_o
);

  digit_t digit [DIGIT_SLOTS];
  logic   carry [DIGIT_SLOTS];

  for (genvar i = 0; i < DIGIT_SLOTS; i++) begin : g_cell
    digit_t din;
    logic   cin;
    if (i == 0) begin : g_first
      assign din = '0;
      assign cin = bit_i;
    end else begin : g_rest
      assign din = digit[i-1];
      assign cin = carry[i-1];
    end
    s2d_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (mode_i),
      .digit_i (din),
      .carry_i (cin),
      .digit_o (digit[i]),
      .carry_o (carry[i])
    );
  end

  // top cell's carry only ever shifts out a zero
  assign top_digit_o = digit[DIGIT_SLOTS-1];

endmodule

### hw/rtl/signed_binary_to_decimal_ascii_top.sv
// Top level: signed binary to decimal ASCII converter built on a row of BCD cells.
// After accept, the magnitude is shifted through the row with add-3 adjust (ST_CONV), a '-' is
// formed for negatives (ST_SIGN), then leading zeros are dropped (ST_SKIP) and the digits walked
// out (ST_EMIT); each character is strobed in the cycle after it is formed.
// A new number is accepted only from ST_IDLE, once the last character has been formed.
// Results cannot be stalled by the receiver. Reset: asynchronous, active low; idle, cells clear.
module signed_binary_to_decimal_ascii_top
  import s2d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [63:0] value_i,
  output logic               strobe_o,
  output logic [5:0]         character_o,
  output logic               last_o
);

  s2d_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d, val_in;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;

  logic       strobe_q, strobe_d;
  logic [5:0] char_q, char_d;
  logic       last_q, last_d;

  s2d_mode_e mode;
  digit_t    top_digit;
  logic      accept, conv_done, top_zero, final_digit;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign conv_done   = (cnt_q == CNT_W'(VALUE_BITS - 1));
  assign top_zero    = (top_digit == '0);
  assign final_digit = (rem_q == REM_W'(1));
  assign val_in      = value_i[VALUE_BITS-1:0];

  // The cell row: magnitude MSB feeds cell 0 during conversion, digits move up on output.
  s2d_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode),
    .bit_i       (mag_q[VALUE_BITS-1]),
    .top_digit_o (top_digit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_CONV;
      ST_CONV: if (conv_done) state_d = neg_q ? ST_SIGN : ST_SKIP;
      ST_SIGN: state_d = ST_SKIP;
      // advance past leading zeros, but always keep the units digit
      ST_SKIP: if (!top_zero || final_digit) state_d = ST_EMIT;
      ST_EMIT: if (final_digit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    mode     = MODE_HOLD;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = 1'b0;
    mag_d    = mag_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          // take the magnitude as unsigned so the most negative value converts cleanly
          neg_d = val_in[VALUE_BITS-1];
          mag_d = val_in[VALUE_BITS-1] ? (~val_in + 1'b1) : val_in;
          cnt_d = '0;
          rem_d = REM_W'(DIGIT_SLOTS);
          mode  = MODE_CLEAR;
        end
      end
      ST_CONV: begin
        mode  = MODE_DABBLE;
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      ST_SIGN: begin
        strobe_d = 1'b1;
        char_d   = ASCII_MINUS;
      end
      ST_SKIP: begin
        if (top_zero && !final_digit) begin
          mode  = MODE_SHIFT;
          rem_d = rem_q - 1'b1;
        end
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        char_d   = ASCII_ZERO + 6'(top_digit);
        last_d   = final_digit;
        mode     = MODE_SHIFT;
        rem_d    = rem_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      neg_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      neg_q    <= neg_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  logic unused_accept;
  assign unused_accept = accept;

endmodule

### hw/rtl/s2d_checker.sv
// Port-level checker for the signed binary to decimal ASCII converter, with its bind.
module s2d_checker
  import s2d_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [63:0] value_i,
  input logic               strobe_o,
  input logic [5:0]         character_o,
  input logic               last_o
);

  logic unused_value;
  assign unused_value = ^value_i;

  // an accepted transaction always starts the conversion
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (character_o == ASCII_MINUS) ||
                 ((character_o >= ASCII_ZERO) && (character_o <= ASCII_ZERO + 6'd9)))
    else $error("character outside '-' and '0'..'9'");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (character_o == ASCII_MINUS) |-> !last_o)
    else $error("minus sign marked as last");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("character straight after the last one");

  a_no_strobe_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> !strobe_o)
    else $error("strobe as a transaction starts");

endmodule

bind signed_binary_to_decimal_ascii_top s2d_checker u_s2d_checker (.*);

### dv/signed_binary_to_decimal_ascii_top_test.sv
// Testbench for the signed binary to decimal ASCII converter: directed and random numbers.
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_top_test;
  import s2d_pkg::*;

  // Base of the decimal expansion done by the predictor.
  localparam logic [63:0] DECIMAL_RADIX = 64'd10;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int          HANG_LIMIT    = 2000;
  // Cycles to keep watching after the last character, to catch stray strobes.
  localparam int          TAIL_CYCLES   = 120;
  // Chance in a hundred that the sender idles before a number.
  localparam int          IDLE_PERCENT  = 31;

  typedef struct packed {
    logic [5:0] code;
    logic       is_last;
  } ascii_char_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic signed [63:0] value_i     = '0;
  logic               busy_o;
  logic               strobe_o;
  logic [5:0]         character_o;
  logic               last_o;

  // Characters still owed by the block, oldest first.
  ascii_char_t pending_chars[$];
  int          error_count    = 0;
  int          stalled_cycles = 0;
  bit          sender_idles   = 1'b1;

  signed_binary_to_decimal_ascii_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Work out the text of one number and queue its characters.
  // Only the low VALUE_BITS bits count; the top one of them is the sign.
  // The magnitude is formed unsigned, so the most negative value needs no special path.
  function automatic void predict_decimal_text(input logic [63:0] raw);
    logic [63:0] mask;
    logic [63:0] bits;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [3:0]  digits [DIGIT_SLOTS];
    logic        negative;
    int          n;
    mask     = {64{1'b1}} >> (64 - VALUE_BITS);
    bits     = raw & mask;
    negative = bits[VALUE_BITS-1];
    mag      = negative ? ((~bits + 64'd1) & mask) : bits;
    n        = 0;
    // Split into digits, least significant first; zero still yields one digit.
    do begin
      rem       = mag % DECIMAL_RADIX;
      digits[n] = rem[3:0];
      n++;
      mag       = mag / DECIMAL_RADIX;
    end while (mag != 64'd0);
    if (negative) pending_chars.push_back('{code: ASCII_MINUS, is_last: 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back('{code: ASCII_ZERO + {2'b00, digits[i]}, is_last: (i == 0)});
    end
  endfunction

  // Offer one number and hold it until the block takes it. Called at a rising edge.
  task automatic send_number(input logic [63:0] number);
    // Idle for a random stretch now and then, so the next start lands on any
    // phase of the block's work: mid conversion, mid emission or while idle.
    if (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      repeat ($urandom_range(1, 120)) begin
        start_i <= 1'b0;
        value_i <= {$urandom, $urandom};
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    value_i <= number;
    // busy_o read here is its value before the edge, so the edge that finds
    // it low is the one that takes the transaction.
    do @(posedge clk_i); while (busy_o);
    predict_decimal_text(number);
  endtask

  // Drop start and hold off until every owed character has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // Field extremes, zero, the most negative value and digit-count boundaries.
  task automatic test_directed_extremes();
    logic [63:0] corner [22];
    corner = '{
      64'd0,
      64'd1,
      -64'sd1,
      64'd9,
      64'd10,
      -64'sd10,
      64'd99,
      64'd100,
      64'h7FFF_FFFF_FFFF_FFFF,             // largest positive, 19 digits
      64'h8000_0000_0000_0000,             // most negative, magnitude 2^63
      64'h8000_0000_0000_0001,
      64'd1000000000000000000,             // 19 digits, inner zeros
      64'd999999999999999999,              // 18 nines
      -64'sd1000000000000000000,
      -64'sd9000000000000000000,
      64'd1234567890,
      -64'sd1234567890,
      64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA,
      64'h0000_0000_FFFF_FFFF,
      64'hFFFF_FFFF_0000_0000,
      64'd4294967296
    };
    foreach (corner[i]) send_number(corner[i]);
  endtask

  // Uniform 64-bit patterns: mostly 19-digit numbers of either sign.
  task automatic test_random_full_range(input int count);
    repeat (count) send_number({$urandom, $urandom});
  endtask

  // Random magnitudes over every digit count, with a random sign.
  task automatic test_random_digit_lengths(input int count);
    logic [63:0] mag;
    repeat (count) begin
      mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      send_number($urandom_range(1) ? -mag : mag);
    end
  endtask

  // Hold start high throughout: each number follows the last with no gap.
  task automatic test_back_to_back(input int count);
    sender_idles = 1'b0;
    repeat (count) send_number({$urandom, $urandom} >> $urandom_range(0, 63));
    sender_idles = 1'b1;
  endtask

  // Compare each strobed character with the oldest one owed.
  always @(posedge clk_i) begin
    ascii_char_t want;
    if (rst_ni && strobe_o) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                 $time, character_o, last_o);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.code) begin
          $display("%0t: character mismatch: expected %0d, actual %0d",
                   $time, want.code, character_o);
          error_count++;
        end
        if (last_o !== want.is_last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.is_last, last_o);
          error_count++;
        end
      end
    end
  end

  // End the run if neither side moves a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || strobe_o) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles >= HANG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("signed_binary_to_decimal_ascii_top test failed");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    // Pause the sender here until the block has answered everything.
    drain_results();
    test_random_full_range(150);
    test_random_digit_lengths(150);
    drain_results();
    test_back_to_back(100);
    drain_results();

    // Keep watching for a full conversion time, so stray characters are caught.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("signed_binary_to_decimal_ascii_top test passed");
    end else begin
      $display("signed_binary_to_decimal_ascii_top test failed");
    end
    $finish;
  end

endmodule
